@@ rtl/multiset_permutation_generator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Multiset permutation generator assertion macros
// Shared property macros for the checker of the permutation generator core.
// ----------------------------------------------------------------------------
`ifndef MULTISET_PERMUTATION_GENERATOR_CORE_DEFINES_SVH
`define MULTISET_PERMUTATION_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MPG_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define MPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Multiset permutation generator package
// Sizes, codes, payload structs and sequencer states shared by the core.
// ----------------------------------------------------------------------------
package mpg_pkg;

   localparam int MAX_ELEMENTS = 8;
   localparam int VALUE_WIDTH  = 8;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int OPCODE_W     = 2;
   localparam int ITEM_W       = 8;
   localparam int LEN_W        = 4;
   localparam int OUT_ITEMS    = 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_NEXT   = 2'd2
   } opcode_type;

   typedef logic signed [VALUE_WIDTH-1:0] elem_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [ITEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     exists;
      logic                     last;
      logic [LEN_W-1:0]         length;
      logic signed [ITEM_W-1:0] item_zero;
      logic signed [ITEM_W-1:0] item_one;
      logic signed [ITEM_W-1:0] item_two;
      logic signed [ITEM_W-1:0] item_three;
      logic signed [ITEM_W-1:0] item_four;
      logic signed [ITEM_W-1:0] item_five;
      logic signed [ITEM_W-1:0] item_six;
      logic signed [ITEM_W-1:0] item_seven;
   } rsp_type;

   // Element store port group driven by the sequencer.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      elem_type         wr_data;
      logic [IDX_W-1:0] rd_addr_a;
      logic [IDX_W-1:0] rd_addr_b;
   } store_req_type;

   // Collection writes and completion status toward the result register.
   typedef struct packed {
      logic             col_wr;
      logic [IDX_W-1:0] col_idx;
      elem_type         col_data;
      logic             done;
      logic             exists;
      logic             last;
      logic [CNT_W-1:0] length;
   } seq_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_WA,
      S_SORT_WB,
      S_PIV_RD,
      S_PIV_CMP,
      S_SUC_RD,
      S_SUC_CMP,
      S_SWAP_WA,
      S_SWAP_WB,
      S_REV_RD,
      S_REV_WA,
      S_REV_WB,
      S_COL_RD,
      S_COL_CAP,
      S_DONE
   } seq_state_type;

endpackage

@@ rtl/multiset_permutation_generator_core.sv @@
// ----------------------------------------------------------------------------
// Multiset permutation generator core
// Returns the distinct permutations of a loaded multiset in ascending order.
// ----------------------------------------------------------------------------
// Load the store with clear and append commands, then issue next commands:
// each one answers with exactly one rsp_strobe cycle carrying the following
// distinct arrangement in ascending signed lexicographic order, with last set
// on the final one and exists clear once the sequence is used up or the
// store is empty. The receiver cannot stall, so capture rsp_item on the
// strobe. Clear and append produce no transfer. A next command holds busy
// while it runs: the first one after loading runs a bubble sort when there
// are two or more elements, later ones run the pivot scan, successor scan,
// swap and suffix reversal, and each ends in a collection pass; an empty or
// exhausted store answers without any of these steps. The element store has
// a single write port, and one comparator serves every comparison step.
// Appending to a full store drops the element but still restarts the
// sequence from the smallest arrangement.
// ----------------------------------------------------------------------------
module multiset_permutation_generator_core
   import mpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   store_req_type            store_req;
   seq_status_type           status;
   elem_type                 rd_data_a;
   elem_type                 rd_data_b;
   logic                     next_accept;

   // result staging: one register per output position
   logic signed [ITEM_W-1:0] item_ff [OUT_ITEMS];
   logic signed [ITEM_W-1:0] item_in [OUT_ITEMS];
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_strobe_ff;

   mpg_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mpg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .busy      (busy),
      .store_req (store_req),
      .status    (status)
   );

   assign next_accept = start && !busy && (req_item.opcode == OP_NEXT);

   // Drop stale positions on every next command so unused ones read zero,
   // then fill from the collection pass.
   always_comb begin
      for (int i = 0; i < OUT_ITEMS; i++) begin
         item_in[i] = item_ff[i];
      end
      if (next_accept) begin
         for (int i = 0; i < OUT_ITEMS; i++) begin
            item_in[i] = '0;
         end
      end else if (status.col_wr) begin
         item_in[status.col_idx] = ITEM_W'(status.col_data);
      end
   end

   // Hold the finished result apart from the staging registers, so a new
   // command in the strobe cycle cannot disturb the transfer.
   always_comb begin
      rsp_in = rsp_ff;
      if (status.done) begin
         rsp_in.exists     = status.exists;
         rsp_in.last       = status.last;
         rsp_in.length     = LEN_W'(status.length);
         rsp_in.item_zero  = item_ff[0];
         rsp_in.item_one   = item_ff[1];
         rsp_in.item_two   = item_ff[2];
         rsp_in.item_three = item_ff[3];
         rsp_in.item_four  = item_ff[4];
         rsp_in.item_five  = item_ff[5];
         rsp_in.item_six   = item_ff[6];
         rsp_in.item_seven = item_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < OUT_ITEMS; i++) begin
         item_ff[i] <= item_in[i];
      end
      rsp_ff <= rsp_in;
   end

   // Strobe for exactly one cycle after the sequencer finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= status.done;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ rtl/mpg_store.sv @@
// ----------------------------------------------------------------------------
// Multiset permutation generator element store
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mpg_store
   import mpg_pkg::*;
(
   input  logic          clock,
   input  store_req_type store_req,
   output elem_type      rd_data_a,
   output elem_type      rd_data_b
);

   elem_type mem_ff [MAX_ELEMENTS];
   elem_type rd_a_ff;
   elem_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem_ff[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[store_req.rd_addr_a];
      rd_b_ff <= mem_ff[store_req.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/mpg_seq.sv @@
// ----------------------------------------------------------------------------
// Multiset permutation generator sequencer
// Drives the store and one shared signed comparator through sort, pivot
// search, successor search, swap, suffix reversal and result collection.
// ----------------------------------------------------------------------------
module mpg_seq
   import mpg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  req_type        req_item,
   input  elem_type       rd_data_a,
   input  elem_type       rd_data_b,
   output logic           busy,
   output store_req_type  store_req,
   output seq_status_type status
);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             started_ff, started_in;
   logic             exhausted_ff, exhausted_in;
   logic             empty_ff, empty_in;
   logic             ascent_ff, ascent_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] pass_ff, pass_in;
   logic [IDX_W-1:0] p_ff, p_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   elem_type         pv_ff, pv_in;
   elem_type         va_ff, va_in;
   elem_type         vb_ff, vb_in;

   logic             accept;
   logic             full;
   logic             no_perm;
   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] last_pair;
   logic             pair_end;
   logic             pass_end;
   logic [CNT_W-1:0] p_next;
   logic [CNT_W-1:0] lo_next;
   logic [CNT_W-1:0] hi_prev;
   elem_type         cmp_x;
   elem_type         cmp_y;
   logic             cmp_lt;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign full      = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign no_perm   = (count_ff == '0) || exhausted_ff;
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign last_pair = IDX_W'(count_ff - CNT_W'(2));
   assign pair_end  = (idx_ff == last_pair);
   assign pass_end  = (pass_ff == last_pair);
   assign p_next    = CNT_W'(p_ff) + CNT_W'(1);
   assign lo_next   = CNT_W'(lo_ff) + CNT_W'(1);
   assign hi_prev   = CNT_W'(hi_ff) - CNT_W'(1);

   // shared signed comparator
   assign cmp_lt = (cmp_x < cmp_y);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_item.opcode == OP_NEXT)) begin
               if (no_perm) begin
                  state_in = S_DONE;
               end else if (count_ff < CNT_W'(2)) begin
                  state_in = S_COL_RD;
               end else if (!started_ff) begin
                  state_in = S_SORT_RD;
               end else begin
                  state_in = S_PIV_RD;
               end
            end
         end
         S_SORT_RD:  state_in = S_SORT_CMP;
         S_SORT_CMP: begin
            if (cmp_lt) begin
               state_in = S_SORT_WA;
            end else if (pair_end && pass_end) begin
               state_in = S_COL_RD;
            end else begin
               state_in = S_SORT_RD;
            end
         end
         S_SORT_WA:  state_in = S_SORT_WB;
         S_SORT_WB: begin
            if (pair_end && pass_end) begin
               state_in = S_COL_RD;
            end else begin
               state_in = S_SORT_RD;
            end
         end
         S_PIV_RD:   state_in = S_PIV_CMP;
         S_PIV_CMP: begin
            if (cmp_lt) begin
               state_in = S_SUC_RD;
            end else if (idx_ff == '0) begin
               state_in = S_COL_RD;
            end else begin
               state_in = S_PIV_RD;
            end
         end
         S_SUC_RD:   state_in = S_SUC_CMP;
         S_SUC_CMP: begin
            if (cmp_lt) begin
               state_in = S_SWAP_WA;
            end else begin
               state_in = S_SUC_RD;
            end
         end
         S_SWAP_WA:  state_in = S_SWAP_WB;
         S_SWAP_WB: begin
            if (p_next < CNT_W'(last_idx)) begin
               state_in = S_REV_RD;
            end else begin
               state_in = S_COL_RD;
            end
         end
         S_REV_RD:   state_in = S_REV_WA;
         S_REV_WA:   state_in = S_REV_WB;
         S_REV_WB: begin
            if (lo_next < hi_prev) begin
               state_in = S_REV_RD;
            end else begin
               state_in = S_COL_RD;
            end
         end
         S_COL_RD:   state_in = S_COL_CAP;
         S_COL_CAP: begin
            if (idx_ff == last_idx) begin
               state_in = S_DONE;
            end else begin
               state_in = S_COL_RD;
            end
         end
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      store_req.wr_en     = 1'b0;
      store_req.wr_addr   = idx_ff;
      store_req.wr_data   = va_ff;
      store_req.rd_addr_a = idx_ff;
      store_req.rd_addr_b = IDX_W'(idx_ff + IDX_W'(1));
      cmp_x               = rd_data_a;
      cmp_y               = rd_data_b;
      case (state_ff)
         S_IDLE: begin
            store_req.wr_en   = accept && (req_item.opcode == OP_APPEND) && !full;
            store_req.wr_addr = IDX_W'(count_ff);
            store_req.wr_data = elem_type'(req_item.value);
         end
         S_SORT_CMP: begin
            cmp_x = rd_data_b;
            cmp_y = rd_data_a;
         end
         S_SORT_WA: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_data = vb_ff;
         end
         S_SORT_WB: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = IDX_W'(idx_ff + IDX_W'(1));
            store_req.wr_data = va_ff;
         end
         S_SUC_CMP: begin
            cmp_x = pv_ff;
            cmp_y = rd_data_a;
         end
         S_SWAP_WA: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = p_ff;
            store_req.wr_data = vb_ff;
         end
         S_SWAP_WB: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_data = pv_ff;
         end
         S_REV_RD: begin
            store_req.rd_addr_a = lo_ff;
            store_req.rd_addr_b = hi_ff;
         end
         S_REV_WA: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = lo_ff;
            store_req.wr_data = rd_data_b;
         end
         S_REV_WB: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = hi_ff;
            store_req.wr_data = va_ff;
         end
         S_COL_CAP: begin
            cmp_x = va_ff;
            cmp_y = rd_data_a;
         end
         default: begin
         end
      endcase

      status.col_wr   = (state_ff == S_COL_CAP);
      status.col_idx  = idx_ff;
      status.col_data = rd_data_a;
      status.done     = (state_ff == S_DONE);
      status.exists   = !empty_ff;
      status.last     = !empty_ff && !ascent_ff;
      status.length   = empty_ff ? '0 : count_ff;
   end

   always_comb begin
      count_in     = count_ff;
      started_in   = started_ff;
      exhausted_in = exhausted_ff;
      empty_in     = empty_ff;
      ascent_in    = ascent_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      p_in         = p_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pv_in        = pv_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.opcode)
                  OP_CLEAR: begin
                     count_in     = '0;
                     started_in   = 1'b0;
                     exhausted_in = 1'b0;
                  end
                  OP_APPEND: begin
                     if (!full) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     started_in   = 1'b0;
                     exhausted_in = 1'b0;
                  end
                  OP_NEXT: begin
                     empty_in  = no_perm;
                     ascent_in = 1'b0;
                     pass_in   = '0;
                     idx_in    = '0;
                     if (started_ff && (count_ff >= CNT_W'(2))) begin
                        idx_in = last_pair;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SORT_CMP, S_SORT_WB: begin
            if (state_ff == S_SORT_CMP) begin
               va_in = rd_data_a;
               vb_in = rd_data_b;
            end
            // step to the next pair unless a swap is pending
            if ((state_ff == S_SORT_WB) || !cmp_lt) begin
               if (pair_end) begin
                  idx_in  = '0;
                  pass_in = IDX_W'(pass_ff + IDX_W'(1));
               end else begin
                  idx_in = IDX_W'(idx_ff + IDX_W'(1));
               end
            end
         end
         S_PIV_CMP: begin
            if (cmp_lt) begin
               p_in   = idx_ff;
               pv_in  = rd_data_a;
               idx_in = last_idx;
            end else if (idx_ff != '0) begin
               idx_in = IDX_W'(idx_ff - IDX_W'(1));
            end
         end
         S_SUC_CMP: begin
            if (cmp_lt) begin
               vb_in = rd_data_a;
            end else begin
               idx_in = IDX_W'(idx_ff - IDX_W'(1));
            end
         end
         S_SWAP_WB: begin
            lo_in  = IDX_W'(p_next);
            hi_in  = last_idx;
            idx_in = '0;
         end
         S_REV_WA: begin
            va_in = rd_data_a;
         end
         S_REV_WB: begin
            lo_in = IDX_W'(lo_next);
            hi_in = IDX_W'(hi_prev);
         end
         S_COL_CAP: begin
            if ((idx_ff != '0) && cmp_lt) begin
               ascent_in = 1'b1;
            end
            va_in = rd_data_a;
            if (idx_ff != last_idx) begin
               idx_in = IDX_W'(idx_ff + IDX_W'(1));
            end
         end
         S_DONE: begin
            if (!empty_ff) begin
               started_in = 1'b1;
               if (!ascent_ff) begin
                  exhausted_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         exhausted_ff <= 1'b0;
         empty_ff     <= 1'b0;
         ascent_ff    <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         exhausted_ff <= exhausted_in;
         empty_ff     <= empty_in;
         ascent_ff    <= ascent_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      pv_ff <= pv_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
   end

endmodule

@@ rtl/mpg_checker.sv @@
// ----------------------------------------------------------------------------
// Multiset permutation generator checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`include "multiset_permutation_generator_core_defines.svh"

module mpg_checker
   import mpg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   `MPG_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `MPG_ASSERT_HOLDS(a_empty_result_zero, rsp_strobe && !rsp_item.exists, (rsp_item.length == '0) && !rsp_item.last, "empty result carries data")
   `MPG_ASSERT_HOLDS(a_last_needs_exists, rsp_strobe && rsp_item.last, rsp_item.exists, "last set without a permutation")
   `MPG_ASSERT_NEXT(a_next_goes_busy, start && !busy && (req_item.opcode == OP_NEXT), busy, "next command did not start work")
   `MPG_ASSERT_NEXT(a_load_stays_idle, start && !busy && (req_item.opcode != OP_NEXT), !busy && !rsp_strobe, "load command started work")

endmodule

bind multiset_permutation_generator_core mpg_checker u_checker (.*);
